// ----- rtl/kps_pkg.sv -----
// shared types and constants for the keypad scanner
package kps_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int TIMER_W     = 16;
   localparam int COUNT_W     = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SAMPLE_TICKS  = 8'd0,
      REG_HOLD_SAMPLES  = 8'd1,
      REG_LOCKOUT_TICKS = 8'd2,
      REG_PAUSE_TICKS   = 8'd3
   } reg_index_type;

   localparam logic [TIMER_W-1:0] SAMPLE_TICKS_RESET  = 16'd100;
   localparam logic [COUNT_W-1:0] HOLD_SAMPLES_RESET  = 4'd4;
   localparam logic [TIMER_W-1:0] LOCKOUT_TICKS_RESET = 16'd500;
   localparam logic [TIMER_W-1:0] PAUSE_TICKS_RESET   = 16'd60;

   typedef struct packed {
      logic [TIMER_W-1:0] sample_ticks;
      logic [COUNT_W-1:0] hold_samples;
      logic [TIMER_W-1:0] lockout_ticks;
      logic [TIMER_W-1:0] pause_ticks;
   } cfg_type;

endpackage

// ----- rtl/kps_if.sv -----
// channel interfaces for the keypad scanner
interface kps_req_if #(parameter int NUM_COLUMNS = 6);
   logic                   valid;
   logic                   ready;
   logic [NUM_COLUMNS-1:0] column_lines;

   modport source (output valid, output column_lines, input ready);
   modport sink (input valid, input column_lines, output ready);
endinterface

interface kps_rsp_if #(parameter int NUM_ROWS = 4, parameter int NUM_COLUMNS = 6);
   logic                               valid;
   logic                               ready;
   logic [NUM_ROWS-1:0]                row_drive;
   logic                               event_valid;
   logic [$clog2(NUM_COLUMNS+1)-1:0]   key_column;
   logic [$clog2(NUM_ROWS+1)-1:0]      key_row;
   logic                               is_hold;

   modport source (output valid, output row_drive, output event_valid, output key_column,
                   output key_row, output is_hold, input ready);
   modport sink (input valid, input row_drive, input event_valid, input key_column,
                 input key_row, input is_hold, output ready);
endinterface

interface kps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [kps_pkg::CSR_INDEX_W-1:0]  index;
   logic [kps_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/kps_csr.sv -----
// configuration registers of the keypad scanner
module kps_csr (
   input  logic             clock,
   input  logic             reset,
   kps_csr_if.sink          csr_ch,
   output kps_pkg::cfg_type cfg
);

   kps_pkg::cfg_type cfg_ff;
   kps_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (kps_pkg::reg_index_type'(csr_ch.index))
            kps_pkg::REG_SAMPLE_TICKS:  cfg_in.sample_ticks  = csr_ch.data;
            kps_pkg::REG_HOLD_SAMPLES:  cfg_in.hold_samples  = csr_ch.data[kps_pkg::COUNT_W-1:0];
            kps_pkg::REG_LOCKOUT_TICKS: cfg_in.lockout_ticks = csr_ch.data;
            kps_pkg::REG_PAUSE_TICKS:   cfg_in.pause_ticks   = csr_ch.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_ticks  <= kps_pkg::SAMPLE_TICKS_RESET;
         cfg_ff.hold_samples  <= kps_pkg::HOLD_SAMPLES_RESET;
         cfg_ff.lockout_ticks <= kps_pkg::LOCKOUT_TICKS_RESET;
         cfg_ff.pause_ticks   <= kps_pkg::PAUSE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/matrix_keypad_click_hold_scanner_top.sv -----
// top level of the keypad scanner with click and hold detection
//
// usage:
//   req_ch carries one timer tick per item, with the active-low column lines
//   read under the row drive of that tick. rsp_ch returns exactly one item per
//   tick: the row drive for that tick and, when a key decision falls on it,
//   the key event (column, row, click or hold).
//   csr_ch writes the four registers (sample, hold count, lockout, pause);
//   it is always ready and writes to unknown indexes are dropped.
// timing:
//   each tick is handled by the scan state machine and lands in the result
//   register, so a result is valid the cycle after its tick is taken. a new
//   tick is taken every cycle as long as the result register is empty or
//   being emptied, so sustained throughput is one item per cycle.
// reset:
//   synchronous, clears the state machine to scanning from row one, empties
//   the result register and loads the register defaults.
// stall:
//   while rsp_ch is stalled with a result waiting, req_ch ready drops and the
//   scan state stays frozen.
module matrix_keypad_click_hold_scanner_top #(
   parameter int NUM_ROWS    = 4,
   parameter int NUM_COLUMNS = 6
) (
   input  logic      clock,
   input  logic      reset,
   kps_req_if.sink   req_ch,
   kps_rsp_if.source rsp_ch,
   kps_csr_if.sink   csr_ch
);

   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int KEY_ROW_W = $clog2(NUM_ROWS + 1);
   localparam int COL_W    = $clog2(NUM_COLUMNS + 1);
   localparam int TIMER_W  = kps_pkg::TIMER_W;
   localparam int COUNT_W  = kps_pkg::COUNT_W;

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_SAMPLE,
      PH_LOCKOUT,
      PH_PAUSE
   } phase_type;

   kps_pkg::cfg_type cfg;

   kps_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   phase_type            phase_ff, phase_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     held_ff, held_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;

   logic                 rsp_valid_ff;
   logic [NUM_ROWS-1:0]  drive_ff, drive_in;
   logic                 event_ff, event_in;
   logic [COL_W-1:0]     key_col_ff, key_col_in;
   logic [KEY_ROW_W-1:0] key_row_ff, key_row_in;
   logic                 hold_ff, hold_in;

   logic                 accept;
   logic [COL_W-1:0]     hit_col;
   logic [TIMER_W-1:0]   period;
   logic [COUNT_W-1:0]   need;
   logic [COUNT_W:0]     count_plus;
   logic [TIMER_W-1:0]   timer_dec;
   logic [NUM_ROWS-1:0]  row_low;
   phase_type            pause_phase;
   phase_type            lockout_phase;
   logic [TIMER_W-1:0]   lockout_timer;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.row_drive   = drive_ff;
   assign rsp_ch.event_valid = event_ff;
   assign rsp_ch.key_column  = key_col_ff;
   assign rsp_ch.key_row     = key_row_ff;
   assign rsp_ch.is_hold     = hold_ff;

   // lowest-numbered low column wins
   always_comb begin
      hit_col = '0;
      for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
         if (!req_ch.column_lines[c]) begin
            hit_col = COL_W'(c + 1);
         end
      end
   end

   assign period     = (cfg.sample_ticks == '0) ? TIMER_W'(1) : cfg.sample_ticks;
   assign need       = (cfg.hold_samples == '0) ? COUNT_W'(1) : cfg.hold_samples;
   assign count_plus = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign timer_dec  = (timer_ff != '0) ? timer_ff - TIMER_W'(1) : timer_ff;
   assign row_low    = ~(NUM_ROWS'(1) << row_ff);

   assign pause_phase   = (cfg.pause_ticks == '0) ? PH_SCAN : PH_PAUSE;
   assign lockout_phase = (cfg.lockout_ticks == '0) ? pause_phase : PH_LOCKOUT;
   assign lockout_timer = (cfg.lockout_ticks == '0) ? cfg.pause_ticks : cfg.lockout_ticks;

   always_comb begin
      phase_in   = phase_ff;
      row_in     = row_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      timer_in   = timer_ff;
      drive_in   = '1;
      event_in   = 1'b0;
      key_col_in = '0;
      key_row_in = '0;
      hold_in    = 1'b0;
      unique case (phase_ff)
         PH_SCAN: begin
            drive_in = row_low;
            if (hit_col != '0) begin
               held_in  = hit_col;
               count_in = '0;
               timer_in = period;
               phase_in = PH_SAMPLE;
            end else if (row_ff == ROW_W'(NUM_ROWS - 1)) begin
               row_in   = '0;
               phase_in = pause_phase;
               timer_in = cfg.pause_ticks;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         PH_SAMPLE: begin
            drive_in = row_low;
            if (timer_ff > TIMER_W'(1)) begin
               timer_in = timer_ff - TIMER_W'(1);
            end else if (hit_col != held_ff) begin
               event_in   = 1'b1;
               key_col_in = held_ff;
               key_row_in = KEY_ROW_W'(row_ff) + KEY_ROW_W'(1);
               row_in     = '0;
               phase_in   = lockout_phase;
               timer_in   = lockout_timer;
            end else begin
               count_in = count_plus[COUNT_W-1:0];
               if (count_plus >= {1'b0, need}) begin
                  event_in   = 1'b1;
                  key_col_in = held_ff;
                  key_row_in = KEY_ROW_W'(row_ff) + KEY_ROW_W'(1);
                  hold_in    = 1'b1;
                  row_in     = '0;
                  phase_in   = lockout_phase;
                  timer_in   = lockout_timer;
               end else begin
                  timer_in = period;
               end
            end
         end
         PH_LOCKOUT: begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               row_in   = '0;
               phase_in = pause_phase;
               timer_in = cfg.pause_ticks;
            end
         end
         PH_PAUSE: begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               row_in   = '0;
               phase_in = PH_SCAN;
            end
         end
         default: begin
            phase_in = PH_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SCAN;
         row_ff       <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         timer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            row_ff       <= row_in;
            held_ff      <= held_in;
            count_ff     <= count_in;
            timer_ff     <= timer_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         drive_ff   <= drive_in;
         event_ff   <= event_in;
         key_col_ff <= key_col_in;
         key_row_ff <= key_row_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

// ----- bench/matrix_keypad_click_hold_scanner_top_tb.sv -----
// self-checking bench for the keypad scanner: predicts every tick result and compares in order
module matrix_keypad_click_hold_scanner_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ROWS    = 4;
   localparam int NUM_COLUMNS = 6;
   localparam int COL_W       = $clog2(NUM_COLUMNS + 1);
   localparam int ROW_W       = $clog2(NUM_ROWS + 1);
   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 10;
   localparam int PRESS_MAX    = 520;

   localparam logic [kps_pkg::CSR_INDEX_W-1:0] REG_INDEX_SPARE = 8'd4;
   localparam logic [kps_pkg::CSR_INDEX_W-1:0] REG_INDEX_TOP   = 8'hFF;

   localparam logic [NUM_ROWS-1:0]    ROWS_OFF  = '1;
   localparam logic [NUM_COLUMNS-1:0] NO_KEY    = '1;

   typedef enum logic [1:0] {
      SCAN_PH    = 2'd0,
      SAMPLE_PH  = 2'd1,
      LOCKOUT_PH = 2'd2,
      PAUSE_PH   = 2'd3
   } scan_phase_type;

   typedef struct packed {
      logic [NUM_ROWS-1:0] row_drive;
      logic                event_valid;
      logic [COL_W-1:0]    key_column;
      logic [ROW_W-1:0]    key_row;
      logic                is_hold;
   } tick_result_type;

   logic clock;
   logic reset;

   kps_req_if #(.NUM_COLUMNS(NUM_COLUMNS)) req_ch ();
   kps_rsp_if #(.NUM_ROWS(NUM_ROWS), .NUM_COLUMNS(NUM_COLUMNS)) rsp_ch ();
   kps_csr_if csr_ch ();

   matrix_keypad_click_hold_scanner_top #(
      .NUM_ROWS(NUM_ROWS),
      .NUM_COLUMNS(NUM_COLUMNS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // scanner copy: registers
   logic [kps_pkg::TIMER_W-1:0] cfg_sample;
   logic [kps_pkg::COUNT_W-1:0] cfg_hold;
   logic [kps_pkg::TIMER_W-1:0] cfg_lockout;
   logic [kps_pkg::TIMER_W-1:0] cfg_pause;

   // scanner copy: state
   scan_phase_type              kp_phase;
   logic [2:0]                  kp_row;
   logic [COL_W-1:0]            kp_held;
   logic [kps_pkg::COUNT_W-1:0] kp_count;
   logic [kps_pkg::TIMER_W-1:0] kp_timer;

   logic [NUM_COLUMNS-1:0] pending_ticks[$];
   tick_result_type        expected_results[$];

   int error_count;
   int cycle_count;
   int queued_count;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic logic [COL_W-1:0] lowest_pressed(input logic [NUM_COLUMNS-1:0] lines);
      logic [COL_W-1:0] hit;
      hit = '0;
      for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
         if (!lines[c]) begin
            hit = COL_W'(c + 1);
         end
      end
      return hit;
   endfunction

   task automatic start_pause();
      kp_row = '0;
      if (cfg_pause == '0) begin
         kp_phase = SCAN_PH;
      end else begin
         kp_phase = PAUSE_PH;
         kp_timer = cfg_pause;
      end
   endtask

   task automatic start_lockout();
      kp_row = '0;
      if (cfg_lockout == '0) begin
         start_pause();
      end else begin
         kp_phase = LOCKOUT_PH;
         kp_timer = cfg_lockout;
      end
   endtask

   task automatic scan_tick(input logic [NUM_COLUMNS-1:0] lines, output tick_result_type r);
      logic [COL_W-1:0]            hit;
      logic [kps_pkg::COUNT_W-1:0] need;
      logic [kps_pkg::TIMER_W-1:0] reload;
      r = '0;
      r.row_drive = ROWS_OFF;
      reload = (cfg_sample == '0) ? kps_pkg::TIMER_W'(1) : cfg_sample;
      need = (cfg_hold == '0) ? kps_pkg::COUNT_W'(1) : cfg_hold;
      if (kp_row >= NUM_ROWS) begin
         kp_row = '0;
      end
      case (kp_phase)
         SCAN_PH: begin
            r.row_drive = ROWS_OFF & ~(NUM_ROWS'(1) << kp_row);
            hit = lowest_pressed(lines);
            if (hit != '0) begin
               kp_held = hit;
               kp_count = '0;
               kp_timer = reload;
               kp_phase = SAMPLE_PH;
            end else begin
               kp_row = kp_row + 3'd1;
               if (kp_row >= NUM_ROWS) begin
                  start_pause();
               end
            end
         end
         SAMPLE_PH: begin
            r.row_drive = ROWS_OFF & ~(NUM_ROWS'(1) << kp_row);
            if (kp_timer > kps_pkg::TIMER_W'(1)) begin
               kp_timer = kp_timer - kps_pkg::TIMER_W'(1);
            end else begin
               hit = lowest_pressed(lines);
               if (hit != kp_held) begin
                  r.event_valid = 1'b1;
                  r.key_column = kp_held;
                  r.key_row = ROW_W'(kp_row + 3'd1);
                  r.is_hold = 1'b0;
                  start_lockout();
               end else begin
                  kp_count = kp_count + kps_pkg::COUNT_W'(1);
                  if (kp_count >= need) begin
                     r.event_valid = 1'b1;
                     r.key_column = kp_held;
                     r.key_row = ROW_W'(kp_row + 3'd1);
                     r.is_hold = 1'b1;
                     start_lockout();
                  end else begin
                     kp_timer = reload;
                  end
               end
            end
         end
         LOCKOUT_PH: begin
            if (kp_timer > '0) begin
               kp_timer = kp_timer - kps_pkg::TIMER_W'(1);
            end
            if (kp_timer == '0) begin
               start_pause();
            end
         end
         default: begin
            if (kp_timer > '0) begin
               kp_timer = kp_timer - kps_pkg::TIMER_W'(1);
            end
            if (kp_timer == '0) begin
               kp_phase = SCAN_PH;
               kp_row = '0;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // tick driver
   always @(posedge clock) begin
      tick_result_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.column_lines <= NO_KEY;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            scan_tick(req_ch.column_lines, r);
            expected_results.push_back(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.column_lines <= pending_ticks.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      tick_result_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("result item with no expected tick result");
               error_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("row_drive", e.row_drive, rsp_ch.row_drive);
               check_field("event_valid", e.event_valid, rsp_ch.event_valid);
               check_field("key_column", e.key_column, rsp_ch.key_column);
               check_field("key_row", e.key_row, rsp_ch.key_row);
               check_field("is_hold", e.is_hold, rsp_ch.is_hold);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_tick(input logic [NUM_COLUMNS-1:0] lines);
      pending_ticks.push_back(lines);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [kps_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [kps_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         kps_pkg::REG_SAMPLE_TICKS:  cfg_sample = val;
         kps_pkg::REG_HOLD_SAMPLES:  cfg_hold = val[kps_pkg::COUNT_W-1:0];
         kps_pkg::REG_LOCKOUT_TICKS: cfg_lockout = val;
         kps_pkg::REG_PAUSE_TICKS:   cfg_pause = val;
         default: ;
      endcase
   endtask

   task automatic program_scanner(input logic [kps_pkg::TIMER_W-1:0] st,
                                  input logic [kps_pkg::COUNT_W-1:0] hs,
                                  input logic [kps_pkg::TIMER_W-1:0] lo,
                                  input logic [kps_pkg::TIMER_W-1:0] pa);
      write_reg(kps_pkg::REG_SAMPLE_TICKS, st);
      write_reg(kps_pkg::REG_HOLD_SAMPLES, {12'($urandom), hs});
      write_reg(kps_pkg::REG_LOCKOUT_TICKS, lo);
      write_reg(kps_pkg::REG_PAUSE_TICKS, pa);
   endtask

   function automatic logic [NUM_COLUMNS-1:0] key_lines(input int c);
      logic [NUM_COLUMNS-1:0] lines;
      lines = NUM_COLUMNS'($urandom);
      for (int j = 0; j < c; j++) begin
         lines[j] = 1'b1;
      end
      lines[c] = 1'b0;
      return lines;
   endfunction

   // mostly press and release sequences, some raw noise
   task automatic fill_keys(input int count);
      int target;
      int gap;
      int c;
      int c2;
      int len;
      int sw;
      int st_eff;
      target = queued_count + count;
      while (queued_count < target) begin
         if ($urandom_range(99) < 75) begin
            gap = $urandom_range(10);
            repeat (gap) push_tick(NO_KEY);
            c = $urandom_range(NUM_COLUMNS - 1);
            c2 = $urandom_range(NUM_COLUMNS - 1);
            st_eff = (cfg_sample == '0) ? 1 : ((cfg_sample > 120) ? 120 : int'(cfg_sample));
            len = $urandom_range(st_eff * (int'(cfg_hold) + 1) + 3, 1);
            if (len > PRESS_MAX) begin
               len = PRESS_MAX;
            end
            sw = ($urandom_range(99) < 20) ? $urandom_range(len, 1) : len + 1;
            for (int k = 0; k < len; k++) begin
               push_tick(key_lines((k >= sw) ? c2 : c));
            end
         end else begin
            repeat ($urandom_range(6, 1)) push_tick(NUM_COLUMNS'($urandom));
         end
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      queued_count = 0;
      send_idle_pct = 11;
      recv_idle_pct = 52;
      cfg_sample = kps_pkg::SAMPLE_TICKS_RESET;
      cfg_hold = kps_pkg::HOLD_SAMPLES_RESET;
      cfg_lockout = kps_pkg::LOCKOUT_TICKS_RESET;
      cfg_pause = kps_pkg::PAUSE_TICKS_RESET;
      kp_phase = SCAN_PH;
      kp_row = '0;
      kp_held = '0;
      kp_count = '0;
      kp_timer = '0;
      reset <= 1'b1;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: three idle rows under reset settings
      repeat (3) push_tick(NO_KEY);
      wait_drained();
      program_scanner(16'd1, 4'd1, 16'd0, 16'd0);
      push_tick(NO_KEY);
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         push_tick(NO_KEY & ~(NUM_COLUMNS'(1) << c));
         push_tick(NO_KEY & ~(NUM_COLUMNS'(1) << c));
      end
      // column changes before the sample: click
      push_tick('0);
      push_tick(6'h3D);
      wait_drained();
      // zero sample ticks and zero hold count both act as one
      write_reg(kps_pkg::REG_SAMPLE_TICKS, 16'd0);
      write_reg(kps_pkg::REG_HOLD_SAMPLES, 16'hFFF0);
      write_reg(REG_INDEX_SPARE, 16'h0003);
      write_reg(REG_INDEX_TOP, 16'hFFFF);
      push_tick(6'h3E);
      push_tick(6'h3E);
      push_tick(NO_KEY);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 11;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p)
            0: program_scanner(16'd100, 4'd4, 16'd500, 16'd60);
            2: program_scanner(16'd1, 4'd15, 16'd0, 16'd0);
            4: program_scanner(16'd2, 4'd0, 16'd1, 16'd0);
            7: program_scanner(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF);
            default: program_scanner(16'($urandom_range(4, 1)), 4'($urandom_range(4, 1)),
                                     16'($urandom_range(6)), 16'($urandom_range(6)));
         endcase
         if (p == 1) begin
            fill_keys(110);
            wait_drained();
            fill_keys(110);
         end else if (p == 7) begin
            fill_keys(60);
         end else begin
            fill_keys((p == 0) ? 250 : 150);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/kps_pkg.sv
rtl/kps_if.sv
rtl/kps_csr.sv
rtl/matrix_keypad_click_hold_scanner_top.sv
bench/matrix_keypad_click_hold_scanner_top_tb.sv
